// ----- sv/lbr_pkg.sv -----
// Shared types and constants of the line and box rasterizer.
package lbr_pkg;

    localparam logic [2:0] OP_PSET  = 3'd0;
    localparam logic [2:0] OP_POINT = 3'd1;
    localparam logic [2:0] OP_LINE  = 3'd2;
    localparam logic [2:0] OP_BOX   = 3'd3;
    localparam logic [2:0] OP_FILL  = 3'd4;

    localparam logic [2:0] CFG_CLIP_EN  = 3'd0;
    localparam logic [2:0] CFG_CLIP_L   = 3'd1;
    localparam logic [2:0] CFG_CLIP_T   = 3'd2;
    localparam logic [2:0] CFG_CLIP_R   = 3'd3;
    localparam logic [2:0] CFG_CLIP_B   = 3'd4;
    localparam logic [2:0] CFG_FRAME_W  = 3'd5;

    localparam logic [9:0] RST_CLIP_R  = 10'd639;
    localparam logic [7:0] RST_CLIP_B  = 8'd199;
    localparam logic [9:0] RST_FRAME_W = 10'd640;

    typedef struct packed {
        logic        clip_en;
        logic [9:0]  clip_left;
        logic [7:0]  clip_top;
        logic [9:0]  clip_right;
        logic [7:0]  clip_bottom;
        logic [9:0]  frame_width;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] xe;
        logic signed [15:0] ye;
        logic [3:0]         color;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
    } t_cmd;

endpackage

// ----- sv/line_box_rasterizer.sv -----
// Top level of the line and box rasterizer: configuration registers and module wiring.
// A request passes through the queue, then holds the engine while it visits its pixels, with a
// setup step per line segment, box edge or fill; an empty fill or an unused code draws nothing.
// A line visits max(|dx|,|dy|)+1 pixels, a box the sum over its edges. Reset restores the
// registers and runs a clearing pass over all MAX_WIDTH*FRAME_HEIGHT entries of the frame
// store before the first request is drawn.
module line_box_rasterizer import lbr_pkg::*; #(
    parameter int MAX_WIDTH    = 640,
    parameter int FRAME_HEIGHT = 200
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_y_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_y_end,
    input  logic [3:0]         i_pen_color,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_read_color,
    output logic signed [15:0] o_cursor_x,
    output logic signed [15:0] o_cursor_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd, queue_cmd;
    logic push, pop, q_full, q_avail;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_en     <= 1'b0;
            r_cfg.clip_left   <= '0;
            r_cfg.clip_top    <= '0;
            r_cfg.clip_right  <= RST_CLIP_R;
            r_cfg.clip_bottom <= RST_CLIP_B;
            r_cfg.frame_width <= RST_FRAME_W;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLIP_EN: r_cfg.clip_en     <= i_cfg_data[0];
                CFG_CLIP_L:  r_cfg.clip_left   <= i_cfg_data;
                CFG_CLIP_T:  r_cfg.clip_top    <= i_cfg_data[7:0];
                CFG_CLIP_R:  r_cfg.clip_right  <= i_cfg_data;
                CFG_CLIP_B:  r_cfg.clip_bottom <= i_cfg_data[7:0];
                CFG_FRAME_W: r_cfg.frame_width <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_pen_color (i_pen_color),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    lbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_cmd   (queue_cmd)
    );

    lbr_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_avail      (q_avail),
        .i_cmd        (queue_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_color (o_read_color),
        .o_cursor_x   (o_cursor_x),
        .o_cursor_y   (o_cursor_y)
    );

endmodule

// ----- sv/lbr_front.sv -----
// Front end: accepts requests, tracks the last position and forms queue entries.
module lbr_front import lbr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_y_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_y_end,
    input  logic [3:0]         i_pen_color,
    input  logic               i_q_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic signed [15:0] r_pos_x, r_pos_y;
    logic signed [15:0] n_pos_x, n_pos_y;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        unique case (i_operation)
            OP_PSET: begin
                n_pos_x = i_x_start;
                n_pos_y = i_y_start;
            end
            OP_LINE, OP_BOX, OP_FILL: begin
                n_pos_x = i_x_end;
                n_pos_y = i_y_end;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd.op    = i_operation;
        o_cmd.xs    = i_x_start;
        o_cmd.ys    = i_y_start;
        o_cmd.xe    = i_x_end;
        o_cmd.ye    = i_y_end;
        o_cmd.color = i_pen_color;
        o_cmd.cur_x = n_pos_x;
        o_cmd.cur_y = n_pos_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (o_push) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end

endmodule

// ----- sv/lbr_queue.sv -----
// Four-entry command queue between the front end and the drawing engine.
module lbr_queue import lbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_cmd o_cmd
);

    t_cmd       r_ent [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_avail = (r_cnt != 3'd0);
    assign o_cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

endmodule

// ----- sv/lbr_back.sv -----
// Drawing engine: pixel sequencer, frame store with clearing pass and result register.
module lbr_back import lbr_pkg::*; #(
    parameter int MAX_WIDTH    = 640,
    parameter int FRAME_HEIGHT = 200
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_avail,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_read_color,
    output logic signed [15:0] o_cursor_x,
    output logic signed [15:0] o_cursor_y
);

    localparam int DEPTH = MAX_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(FRAME_HEIGHT);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PIX    = 4'd2;
    localparam logic [3:0] S_LSET   = 4'd3;
    localparam logic [3:0] S_LINE   = 4'd4;
    localparam logic [3:0] S_FSET   = 4'd5;
    localparam logic [3:0] S_FILL   = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    logic [3:0]         r_state, n_state;
    t_cmd               r_cmd;
    logic [1:0]         r_seg;
    logic [AW-1:0]      r_clr;
    logic signed [15:0] r_cx, r_cy, r_ex, r_ey, r_flo_x;
    logic signed [19:0] r_dx, r_dy, r_err;
    logic               r_sxn, r_syn;
    logic               r_a_valid;

    logic signed [16:0] wv, wl, wr, wt, wb;
    logic signed [16:0] fw_s, max_s;

    always_comb begin
        fw_s  = {7'b0, i_cfg.frame_width};
        max_s = 17'(MAX_WIDTH);
        wv    = (fw_s > max_s) ? max_s : fw_s;
        wl    = 17'sd0;
        wt    = 17'sd0;
        wr    = wv - 17'sd1;
        wb    = 17'(FRAME_HEIGHT - 1);
        if (i_cfg.clip_en) begin
            wl = {7'b0, i_cfg.clip_left};
            wt = {9'b0, i_cfg.clip_top};
            if ($signed({7'b0, i_cfg.clip_right}) < wr) begin
                wr = {7'b0, i_cfg.clip_right};
            end
            if ($signed({9'b0, i_cfg.clip_bottom}) < wb) begin
                wb = {9'b0, i_cfg.clip_bottom};
            end
        end
    end

    // Segment endpoints for the current line or box edge.
    logic signed [15:0] seg_ax, seg_ay, seg_bx, seg_by;
    logic signed [16:0] ddx, ddy, adx, ady;

    always_comb begin
        seg_ax = r_cmd.xs;
        seg_ay = r_cmd.ys;
        seg_bx = r_cmd.xe;
        seg_by = r_cmd.ye;
        if (r_cmd.op == OP_BOX) begin
            case (r_seg)
                2'd0: begin
                    seg_ax = r_cmd.xs; seg_ay = r_cmd.ys;
                    seg_bx = r_cmd.xe; seg_by = r_cmd.ys;
                end
                2'd1: begin
                    seg_ax = r_cmd.xe; seg_ay = r_cmd.ys;
                    seg_bx = r_cmd.xe; seg_by = r_cmd.ye;
                end
                2'd2: begin
                    seg_ax = r_cmd.xe; seg_ay = r_cmd.ye;
                    seg_bx = r_cmd.xs; seg_by = r_cmd.ye;
                end
                default: begin
                    seg_ax = r_cmd.xs; seg_ay = r_cmd.ye;
                    seg_bx = r_cmd.xs; seg_by = r_cmd.ys;
                end
            endcase
        end
        ddx = 17'(seg_bx) - 17'(seg_ax);
        ddy = 17'(seg_by) - 17'(seg_ay);
        adx = (ddx < 0) ? -ddx : ddx;
        ady = (ddy < 0) ? -ddy : ddy;
    end

    // Fill bounds clipped to the writable window.
    logic signed [16:0] f_xlo, f_xhi, f_ylo, f_yhi;

    always_comb begin
        f_xlo = (r_cmd.xs < r_cmd.xe) ? 17'(r_cmd.xs) : 17'(r_cmd.xe);
        f_xhi = (r_cmd.xs < r_cmd.xe) ? 17'(r_cmd.xe) : 17'(r_cmd.xs);
        f_ylo = (r_cmd.ys < r_cmd.ye) ? 17'(r_cmd.ys) : 17'(r_cmd.ye);
        f_yhi = (r_cmd.ys < r_cmd.ye) ? 17'(r_cmd.ye) : 17'(r_cmd.ys);
        if (f_xlo < wl) f_xlo = wl;
        if (f_xhi > wr) f_xhi = wr;
        if (f_ylo < wt) f_ylo = wt;
        if (f_yhi > wb) f_yhi = wb;
    end

    logic signed [15:0] r_fhi_x, r_fhi_y;
    logic signed [20:0] e2;
    logic               step_x, step_y, at_end;

    assign e2     = {r_err, 1'b0};
    assign step_x = (e2 >= 21'(r_dy));
    assign step_y = (e2 <= 21'(r_dx));
    assign at_end = (r_cx == r_ex) && (r_cy == r_ey);

    logic               emit_v, emit_re;
    logic signed [15:0] emit_x, emit_y;

    always_comb begin
        emit_v  = (r_state == S_PIX) || (r_state == S_LINE) || (r_state == S_FILL);
        emit_re = (r_state == S_PIX) && (r_cmd.op == OP_POINT);
        emit_x  = (r_state == S_PIX) ? r_cmd.xs : r_cx;
        emit_y  = (r_state == S_PIX) ? r_cmd.ys : r_cy;
    end

    assign o_pop = (r_state == S_IDLE) && i_avail;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_avail) begin
                    unique case (i_cmd.op)
                        OP_PSET, OP_POINT: n_state = S_PIX;
                        OP_LINE, OP_BOX:   n_state = S_LSET;
                        OP_FILL:           n_state = S_FSET;
                        default:           n_state = S_DRAIN;
                    endcase
                end
            end
            S_PIX:  n_state = S_DRAIN;
            S_LSET: n_state = S_LINE;
            S_LINE: begin
                if (at_end) begin
                    n_state = (r_cmd.op == OP_BOX && r_seg != 2'd3) ? S_LSET : S_DRAIN;
                end
            end
            S_FSET: n_state = (f_xlo > f_xhi || f_ylo > f_yhi) ? S_DRAIN : S_FILL;
            S_FILL: if (r_cx == r_fhi_x && r_cy == r_fhi_y) n_state = S_DRAIN;
            S_DRAIN: if (!r_a_valid) n_state = S_RESULT;
            S_RESULT: if (!o_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_seg <= 2'd0;
        end
        case (r_state)
            S_LSET: begin
                r_cx  <= seg_ax;
                r_cy  <= seg_ay;
                r_ex  <= seg_bx;
                r_ey  <= seg_by;
                r_dx  <= 20'(adx);
                r_dy  <= -20'(ady);
                r_err <= 20'(adx) - 20'(ady);
                r_sxn <= !(seg_ax < seg_bx);
                r_syn <= !(seg_ay < seg_by);
            end
            S_LINE: begin
                if (at_end) begin
                    r_seg <= r_seg + 2'd1;
                end else begin
                    r_err <= r_err + (step_x ? r_dy : 20'sd0) + (step_y ? r_dx : 20'sd0);
                    if (step_x) r_cx <= r_sxn ? r_cx - 16'sd1 : r_cx + 16'sd1;
                    if (step_y) r_cy <= r_syn ? r_cy - 16'sd1 : r_cy + 16'sd1;
                end
            end
            S_FSET: begin
                r_cx    <= f_xlo[15:0];
                r_cy    <= f_ylo[15:0];
                r_flo_x <= f_xlo[15:0];
                r_fhi_x <= f_xhi[15:0];
                r_fhi_y <= f_yhi[15:0];
            end
            S_FILL: begin
                if (r_cx == r_fhi_x) begin
                    r_cx <= r_flo_x;
                    r_cy <= r_cy + 16'sd1;
                end else begin
                    r_cx <= r_cx + 16'sd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Pixel stage: window test and row offset multiply.
    logic               r_a_we, r_a_re, r_a_hit;
    logic [AW-1:0]      r_a_prod;
    logic [XW-1:0]      r_a_x;
    logic [3:0]         r_a_color;
    logic               in_win, in_frame;

    always_comb begin
        in_win   = (17'(emit_x) >= wl) && (17'(emit_x) <= wr)
                && (17'(emit_y) >= wt) && (17'(emit_y) <= wb);
        in_frame = (emit_x >= 16'sd0) && (17'(emit_x) < wv)
                && (emit_y >= 16'sd0) && (17'(emit_y) < 17'(FRAME_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= emit_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_we    <= emit_v && !emit_re && in_win;
        r_a_re    <= emit_re;
        r_a_hit   <= in_frame;
        r_a_x     <= emit_x[XW-1:0];
        r_a_color <= r_cmd.color;
        r_a_prod  <= {{(AW-YW){1'b0}}, emit_y[YW-1:0]} * {{(AW-WW){1'b0}}, wv[WW-1:0]};
    end

    logic [3:0]    r_mem [DEPTH];
    logic [3:0]    r_mem_q;
    logic          r_rd_hit;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [3:0]    mem_d;

    assign mem_we   = (r_state == S_CLEAR) || (r_a_valid && r_a_we);
    assign mem_addr = (r_state == S_CLEAR) ? r_clr : r_a_prod + {{(AW-XW){1'b0}}, r_a_x};
    assign mem_d    = (r_state == S_CLEAR) ? 4'd0 : r_a_color;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_d;
        end
        if (r_a_valid && r_a_re) begin
            r_mem_q  <= r_mem[mem_addr];
            r_rd_hit <= r_a_hit;
        end
    end

    logic r_o_valid;
    assign o_out_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_RESULT && (!r_o_valid || !i_out_stall)) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && (!r_o_valid || !i_out_stall)) begin
            o_read_color <= (r_cmd.op == OP_POINT && r_rd_hit) ? r_mem_q : 4'd0;
            o_cursor_x   <= r_cmd.cur_x;
            o_cursor_y   <= r_cmd.cur_y;
        end
    end

endmodule
